/* hdl/dvrt_pkg.sv */
package dvrt_pkg;

  localparam logic [23:0] UNREACHABLE = 24'd9999999;
  localparam logic [2:0]  SILENCE_MAX = 3'd7;
  localparam logic [2:0]  SILENCE_RST = 3'd3;
  localparam int          MAX_SLOTS   = 32;
  localparam int          CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIMIT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_LOCAL = 2'd2;

  typedef enum logic [2:0] {
    FN_LOAD_ROUTE = 3'd0,
    FN_LOAD_NBR   = 3'd1,
    FN_ADVERT     = 3'd2,
    FN_LINK_COST  = 3'd3,
    FN_TICK       = 3'd4,
    FN_READ       = 3'd5,
    FN_LOOKUP     = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_NSRCH,
    S_TICKN,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic simple;
    logic read_slot;
    logic read_done;
    logic nsrch_start;
    logic nsrch_step;
    logic nbr_take;
    logic scan_start;
    logic scan_step;
    logic op_ok;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       own_hit;
    logic       nbr_hit;
    logic       nbr_flag;
    logic       nbr_last;
    logic       scan_last;
    logic       out_busy;
  } sts_t;

endpackage

/* hdl/distance_vector_route_table.sv */
// loads, unused codes, own-address lookups: straight to result; read: fetch its slot
// lookup: route scan; advert, link cost change: neighbor search, route scan if found
// tick: route scan per neighbor at its silence limit, one route slot per cycle
// throughput: one request at a time, a new one is taken only in the idle state
// reset clears control registers, valid bits, silence counts and handshake state
// route and neighbor contents are not cleared
module distance_vector_route_table #(
  parameter int ROUTE_SLOTS    = 32,
  parameter int NEIGHBOR_SLOTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     func_i,
  input  logic [4:0]                     slot_i,
  input  logic [31:0]                    dest_addr_i,
  input  logic [31:0]                    hop_addr_i,
  input  logic [31:0]                    neighbor_addr_i,
  input  logic [23:0]                    cost_value_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [1:0]                     status_o,
  output logic [31:0]                    out_dest_o,
  output logic [31:0]                    out_next_hop_o,
  output logic [23:0]                    out_cost_o,
  output logic                           out_valid_o
);

  dvrt_pkg::cmd_t cmd;
  dvrt_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  dvrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dvrt_dpath #(
    .ROUTE_SLOTS    (ROUTE_SLOTS),
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .slot_i          (slot_i),
    .dest_addr_i     (dest_addr_i),
    .hop_addr_i      (hop_addr_i),
    .neighbor_addr_i (neighbor_addr_i),
    .cost_value_i    (cost_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_ready_i     (res_ready_i),
    .res_valid_o     (res_valid_o),
    .status_o        (status_o),
    .out_dest_o      (out_dest_o),
    .out_next_hop_o  (out_next_hop_o),
    .out_cost_o      (out_cost_o),
    .out_valid_o     (out_valid_o)
  );

endmodule

/* hdl/dvrt_ctrl.sv */
module dvrt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dvrt_pkg::sts_t sts_i,
  output dvrt_pkg::cmd_t cmd_o
);

  dvrt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dvrt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dvrt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = dvrt_pkg::S_DISPATCH;
        end
      end
      dvrt_pkg::S_DISPATCH: begin
        case (sts_i.func)
          dvrt_pkg::FN_READ: begin
            cmd_o.read_slot = 1'b1;
            state_d         = dvrt_pkg::S_READ;
          end
          dvrt_pkg::FN_ADVERT, dvrt_pkg::FN_LINK_COST: begin
            cmd_o.nsrch_start = 1'b1;
            state_d           = dvrt_pkg::S_NSRCH;
          end
          dvrt_pkg::FN_TICK: begin
            cmd_o.nsrch_start = 1'b1;
            state_d           = dvrt_pkg::S_TICKN;
          end
          dvrt_pkg::FN_LOOKUP: begin
            if (sts_i.own_hit) begin
              cmd_o.simple = 1'b1;
              state_d      = dvrt_pkg::S_EMIT;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = dvrt_pkg::S_SCAN;
            end
          end
          default: begin
            cmd_o.simple = 1'b1;
            state_d      = dvrt_pkg::S_EMIT;
          end
        endcase
      end
      dvrt_pkg::S_READ: begin
        cmd_o.read_done = 1'b1;
        state_d         = dvrt_pkg::S_EMIT;
      end
      dvrt_pkg::S_NSRCH: begin
        if (sts_i.nbr_hit) begin
          cmd_o.nbr_take   = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = dvrt_pkg::S_SCAN;
        end else if (sts_i.nbr_last) begin
          state_d = dvrt_pkg::S_EMIT;
        end else begin
          cmd_o.nsrch_step = 1'b1;
        end
      end
      dvrt_pkg::S_TICKN: begin
        if (sts_i.nbr_flag) begin
          cmd_o.scan_start = 1'b1;
          state_d          = dvrt_pkg::S_SCAN;
        end else if (sts_i.nbr_last) begin
          cmd_o.op_ok = 1'b1;
          state_d     = dvrt_pkg::S_EMIT;
        end else begin
          cmd_o.nsrch_step = 1'b1;
        end
      end
      dvrt_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = dvrt_pkg::S_DRAIN;
        end
      end
      dvrt_pkg::S_DRAIN: begin
        case (sts_i.func)
          dvrt_pkg::FN_TICK: begin
            if (sts_i.nbr_last) begin
              cmd_o.op_ok = 1'b1;
              state_d     = dvrt_pkg::S_EMIT;
            end else begin
              cmd_o.nsrch_step = 1'b1;
              state_d          = dvrt_pkg::S_TICKN;
            end
          end
          dvrt_pkg::FN_LOOKUP: begin
            state_d = dvrt_pkg::S_EMIT;
          end
          default: begin
            cmd_o.op_ok = 1'b1;
            state_d     = dvrt_pkg::S_EMIT;
          end
        endcase
      end
      dvrt_pkg::S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = dvrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dvrt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/dvrt_dpath.sv */
module dvrt_dpath #(
  parameter int ROUTE_SLOTS    = 32,
  parameter int NEIGHBOR_SLOTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic [2:0]                     func_i,
  input  logic [4:0]                     slot_i,
  input  logic [31:0]                    dest_addr_i,
  input  logic [31:0]                    hop_addr_i,
  input  logic [31:0]                    neighbor_addr_i,
  input  logic [23:0]                    cost_value_i,
  input  dvrt_pkg::cmd_t                 cmd_i,
  output dvrt_pkg::sts_t                 sts_o,
  input  logic                           res_ready_i,
  output logic                           res_valid_o,
  output logic [1:0]                     status_o,
  output logic [31:0]                    out_dest_o,
  output logic [31:0]                    out_next_hop_o,
  output logic [23:0]                    out_cost_o,
  output logic                           out_valid_o
);

  // slot field is five bits, so at most that many entries are reachable
  localparam int RS = (ROUTE_SLOTS < dvrt_pkg::MAX_SLOTS) ? ROUTE_SLOTS : dvrt_pkg::MAX_SLOTS;
  localparam int NS = (NEIGHBOR_SLOTS < dvrt_pkg::MAX_SLOTS) ?
                      NEIGHBOR_SLOTS : dvrt_pkg::MAX_SLOTS;
  localparam int RW = (RS > 1) ? $clog2(RS) : 1;
  localparam int NW = (NS > 1) ? $clog2(NS) : 1;

  logic [31:0] own_q;
  logic [2:0]  limit_q;

  logic [2:0]  func_q;
  logic [4:0]  slot_q;
  logic [31:0] dest_q, hop_q, nbr_q;
  logic [23:0] cost_q, link_q, nc_q;

  logic [31:0] nbr_addr_q [NS];
  logic [23:0] nbr_link_q [NS];
  logic [2:0]  nbr_sil_q  [NS];
  logic [NS-1:0] nbr_vld_q;
  logic [NW-1:0] nidx_q;

  logic [31:0] rt_dest_mem [RS];
  logic [31:0] rt_hop_mem  [RS];
  logic [23:0] rt_cost_mem [RS];
  logic [RS-1:0] rt_vld_q;
  logic [RW-1:0] ridx_q, pidx_q;
  logic          pend_q;
  logic [31:0]   rd_dest_q, rd_hop_q;
  logic [23:0]   rd_cost_q;
  logic          found_q;

  logic [1:0]  res_status_q;
  logic [31:0] res_dest_q, res_hop_q;
  logic [23:0] res_cost_q;
  logic        res_vbit_q;

  logic        out_vld_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_dest_q, out_hop_q;
  logic [23:0] out_cost_q;
  logic        out_vbit_q;

  logic          slot_rt_ok, slot_nb_ok;
  logic [RW-1:0] rt_sidx;
  logic [NW-1:0] nb_sidx;
  logic [31:0]   cur_addr;
  logic [24:0]   nc_sum;
  logic [23:0]   nc_sat, cost_sat;
  logic [25:0]   lk_sum, lk_diff, lk_link;
  logic [23:0]   lk_new;
  logic          p_vld, dmatch, hmatch, look_hit;
  logic          we;
  logic [RW-1:0] wa, ra;
  logic [31:0]   w_dest, w_hop;
  logic [23:0]   w_cost;

  assign slot_rt_ok = int'(slot_q) < RS;
  assign slot_nb_ok = int'(slot_q) < NS;
  assign rt_sidx    = slot_q[RW-1:0];
  assign nb_sidx    = slot_q[NW-1:0];
  assign cur_addr   = nbr_addr_q[nidx_q];
  assign cost_sat   = (cost_value_i > dvrt_pkg::UNREACHABLE) ?
                      dvrt_pkg::UNREACHABLE : cost_value_i;
  assign nc_sum     = {1'b0, nbr_link_q[nidx_q]} + {1'b0, cost_q};
  assign nc_sat     = (nc_sum > {1'b0, dvrt_pkg::UNREACHABLE}) ?
                      dvrt_pkg::UNREACHABLE : nc_sum[23:0];

  assign lk_sum  = {2'b0, rd_cost_q} + {2'b0, cost_q};
  assign lk_link = {2'b0, link_q};
  assign lk_diff = lk_sum - lk_link;
  assign lk_new  = (lk_sum < lk_link) ? 24'd0 :
                   (lk_diff > {2'b0, dvrt_pkg::UNREACHABLE}) ?
                   dvrt_pkg::UNREACHABLE : lk_diff[23:0];

  assign p_vld  = pend_q && rt_vld_q[pidx_q];
  assign dmatch = rd_dest_q == dest_q;
  assign hmatch = rd_hop_q == nbr_q;

  assign sts_o.func      = func_q;
  assign sts_o.own_hit   = dest_q == own_q;
  assign sts_o.nbr_hit   = nbr_vld_q[nidx_q] && (cur_addr == nbr_q);
  assign sts_o.nbr_flag  = nbr_vld_q[nidx_q] && (nbr_sil_q[nidx_q] == limit_q);
  assign sts_o.nbr_last  = nidx_q == NW'(NS - 1);
  assign sts_o.scan_last = ridx_q == RW'(RS - 1);
  assign sts_o.out_busy  = out_vld_q && !res_ready_i;

  // route table write and scan update
  always_comb begin
    we       = 1'b0;
    wa       = pidx_q;
    w_dest   = rd_dest_q;
    w_hop    = rd_hop_q;
    w_cost   = rd_cost_q;
    look_hit = 1'b0;
    ra       = cmd_i.read_slot ? rt_sidx : ridx_q;
    if (cmd_i.simple && func_q == dvrt_pkg::FN_LOAD_ROUTE && slot_rt_ok) begin
      we     = 1'b1;
      wa     = rt_sidx;
      w_dest = dest_q;
      w_hop  = hop_q;
      w_cost = cost_q;
    end else begin
      case (func_q)
        dvrt_pkg::FN_ADVERT: begin
          if (p_vld && dmatch && (hmatch || (nc_q < rd_cost_q && hop_q != own_q))) begin
            we     = 1'b1;
            w_hop  = nbr_q;
            w_cost = nc_q;
          end
        end
        dvrt_pkg::FN_LINK_COST: begin
          if (p_vld && hmatch && rd_cost_q < dvrt_pkg::UNREACHABLE) begin
            we     = 1'b1;
            w_cost = lk_new;
          end
        end
        dvrt_pkg::FN_TICK: begin
          if (p_vld && rd_hop_q == cur_addr) begin
            we     = 1'b1;
            w_hop  = '0;
            w_cost = dvrt_pkg::UNREACHABLE;
          end
        end
        dvrt_pkg::FN_LOOKUP: begin
          look_hit = p_vld && dmatch && !found_q;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      rt_dest_mem[wa] <= w_dest;
      rt_hop_mem[wa]  <= w_hop;
      rt_cost_mem[wa] <= w_cost;
    end
    if (cmd_i.scan_step || cmd_i.read_slot) begin
      rd_dest_q <= rt_dest_mem[ra];
      rd_hop_q  <= rt_hop_mem[ra];
      rd_cost_q <= rt_cost_mem[ra];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q     <= '0;
      limit_q   <= dvrt_pkg::SILENCE_RST;
      rt_vld_q  <= '0;
      nbr_vld_q <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      nidx_q    <= '0;
      ridx_q    <= '0;
      pidx_q    <= '0;
      for (int n = 0; n < NS; n++) begin
        nbr_sil_q[n] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == dvrt_pkg::REG_OWN_ADDRESS) begin
          own_q <= cfg_data_i;
        end else if (cfg_index_i == dvrt_pkg::REG_SILENCE_LIMIT) begin
          limit_q <= cfg_data_i[2:0];
        end
      end
      pend_q <= cmd_i.scan_step;
      pidx_q <= ridx_q;
      if (cmd_i.capture) begin
        found_q <= 1'b0;
      end
      if (look_hit) begin
        found_q <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        ridx_q <= '0;
      end else if (cmd_i.scan_step) begin
        ridx_q <= ridx_q + 1'b1;
      end
      if (cmd_i.nsrch_start) begin
        nidx_q <= '0;
      end else if (cmd_i.nsrch_step) begin
        nidx_q <= nidx_q + 1'b1;
      end
      if (cmd_i.simple && func_q == dvrt_pkg::FN_LOAD_ROUTE && slot_rt_ok) begin
        rt_vld_q[rt_sidx] <= 1'b1;
      end
      if (cmd_i.simple && func_q == dvrt_pkg::FN_LOAD_NBR && slot_nb_ok) begin
        nbr_vld_q[nb_sidx] <= 1'b1;
        nbr_sil_q[nb_sidx] <= '0;
      end
      if (cmd_i.nbr_take && func_q == dvrt_pkg::FN_ADVERT) begin
        nbr_sil_q[nidx_q] <= '0;
      end
      if (cmd_i.op_ok && func_q == dvrt_pkg::FN_TICK) begin
        for (int n = 0; n < NS; n++) begin
          if (nbr_vld_q[n] && nbr_sil_q[n] < dvrt_pkg::SILENCE_MAX) begin
            nbr_sil_q[n] <= nbr_sil_q[n] + 3'd1;
          end
        end
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q       <= func_i;
      slot_q       <= slot_i;
      dest_q       <= dest_addr_i;
      hop_q        <= hop_addr_i;
      nbr_q        <= neighbor_addr_i;
      cost_q       <= cost_sat;
      res_status_q <= dvrt_pkg::ST_NONE;
      res_dest_q   <= '0;
      res_hop_q    <= '0;
      res_cost_q   <= '0;
      res_vbit_q   <= 1'b0;
    end
    if (cmd_i.simple) begin
      case (func_q)
        dvrt_pkg::FN_LOAD_ROUTE: begin
          if (slot_rt_ok) begin
            res_status_q <= dvrt_pkg::ST_OK;
          end
        end
        dvrt_pkg::FN_LOAD_NBR: begin
          if (slot_nb_ok) begin
            res_status_q        <= dvrt_pkg::ST_OK;
            nbr_addr_q[nb_sidx] <= nbr_q;
            nbr_link_q[nb_sidx] <= cost_q;
          end
        end
        dvrt_pkg::FN_LOOKUP: begin
          res_status_q <= dvrt_pkg::ST_LOCAL;
          res_dest_q   <= dest_q;
          res_hop_q    <= own_q;
        end
        default: begin
          res_status_q <= dvrt_pkg::ST_NONE;
        end
      endcase
    end
    if (cmd_i.read_done && slot_rt_ok && rt_vld_q[rt_sidx]) begin
      res_status_q <= dvrt_pkg::ST_OK;
      res_dest_q   <= rd_dest_q;
      res_hop_q    <= rd_hop_q;
      res_cost_q   <= rd_cost_q;
      res_vbit_q   <= 1'b1;
    end
    if (cmd_i.nbr_take) begin
      link_q <= nbr_link_q[nidx_q];
      nc_q   <= nc_sat;
    end
    if (look_hit) begin
      res_status_q <= dvrt_pkg::ST_OK;
      res_dest_q   <= dest_q;
      res_hop_q    <= rd_hop_q;
      res_cost_q   <= rd_cost_q;
      res_vbit_q   <= 1'b1;
    end
    if (cmd_i.op_ok) begin
      res_status_q <= dvrt_pkg::ST_OK;
      if (func_q == dvrt_pkg::FN_LINK_COST) begin
        nbr_link_q[nidx_q] <= cost_q;
      end
    end
    if (cmd_i.emit) begin
      out_status_q <= res_status_q;
      out_dest_q   <= res_dest_q;
      out_hop_q    <= res_hop_q;
      out_cost_q   <= res_cost_q;
      out_vbit_q   <= res_vbit_q;
    end
  end

  assign res_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign out_dest_o     = out_dest_q;
  assign out_next_hop_o = out_hop_q;
  assign out_cost_o     = out_cost_q;
  assign out_valid_o    = out_vbit_q;

endmodule

/* hdl/dvrt_checker.sv */
module dvrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] out_dest_o,
  input logic [31:0] out_next_hop_o,
  input logic [23:0] out_cost_o,
  input logic        out_valid_o
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(status_o) &&
    $stable(out_dest_o) && $stable(out_next_hop_o) && $stable(out_cost_o))
    else $error("result changed while stalled");

  a_vbit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && out_valid_o |-> status_o == dvrt_pkg::ST_OK)
    else $error("route returned with bad status");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != dvrt_pkg::ST_OK |-> out_cost_o == '0 && !out_valid_o)
    else $error("failed request carries data");

  a_cost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_cost_o <= dvrt_pkg::UNREACHABLE)
    else $error("cost above unreachable");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int NR = 32;
  localparam int NN = 8;
  localparam int WATCHDOG = 20000;
  localparam logic [2:0] FN_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [dvrt_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] func_i = '0;
  logic [4:0] slot_i = '0;
  logic [31:0] dest_addr_i = '0, hop_addr_i = '0, neighbor_addr_i = '0;
  logic [23:0] cost_value_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic [1:0] status_o;
  logic [31:0] out_dest_o, out_next_hop_o;
  logic [23:0] out_cost_o;
  logic out_valid_o;

  distance_vector_route_table uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [2:0] func;
    logic [4:0] slot;
    logic [31:0] dest, hop, nbr;
    logic [23:0] cost;
  } route_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] dest, hop;
    logic [23:0] cost;
    logic vld;
  } route_res_t;

  // predictor state
  logic [31:0] p_own;
  logic [2:0] p_limit;
  logic [31:0] p_rdest [NR];
  logic [31:0] p_rhop [NR];
  logic [23:0] p_rcost [NR];
  logic p_rvalid [NR];
  logic [31:0] p_naddr [NN];
  logic [23:0] p_nlink [NN];
  logic [2:0] p_nsil [NN];
  logic p_nvalid [NN];

  route_res_t pending_res [$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int send_idle = 0, recv_idle = 0;
  int lookups_hit = 0, adverts_taken = 0;

  function automatic logic [23:0] clamp_cost(longint c);
    if (c < 0) return 24'd0;
    if (c > longint'(dvrt_pkg::UNREACHABLE)) return dvrt_pkg::UNREACHABLE;
    return c[23:0];
  endfunction

  function automatic int nbr_index(logic [31:0] a);
    for (int i = 0; i < NN; i++)
      if (p_nvalid[i] && p_naddr[i] == a) return i;
    return -1;
  endfunction

  function automatic route_res_t route_predict(route_req_t r);
    route_res_t o;
    logic [23:0] c, nc;
    int n;
    o = '0;
    o.status = dvrt_pkg::ST_NONE;
    c = clamp_cost(longint'(r.cost));
    case (r.func)
      dvrt_pkg::FN_LOAD_ROUTE: begin
        p_rdest[r.slot] = r.dest;
        p_rhop[r.slot] = r.hop;
        p_rcost[r.slot] = c;
        p_rvalid[r.slot] = 1'b1;
        o.status = dvrt_pkg::ST_OK;
      end
      dvrt_pkg::FN_LOAD_NBR: begin
        if (r.slot < NN) begin
          p_naddr[r.slot] = r.nbr;
          p_nlink[r.slot] = c;
          p_nsil[r.slot] = '0;
          p_nvalid[r.slot] = 1'b1;
          o.status = dvrt_pkg::ST_OK;
        end
      end
      dvrt_pkg::FN_ADVERT: begin
        n = nbr_index(r.nbr);
        if (n >= 0) begin
          nc = clamp_cost(longint'(p_nlink[n]) + longint'(c));
          p_nsil[n] = '0;
          for (int i = 0; i < NR; i++)
            if (p_rvalid[i] && p_rdest[i] == r.dest &&
                (p_rhop[i] == r.nbr || (nc < p_rcost[i] && r.hop != p_own))) begin
              p_rcost[i] = nc;
              p_rhop[i] = r.nbr;
              adverts_taken++;
            end
          o.status = dvrt_pkg::ST_OK;
        end
      end
      dvrt_pkg::FN_LINK_COST: begin
        n = nbr_index(r.nbr);
        if (n >= 0) begin
          for (int i = 0; i < NR; i++)
            if (p_rvalid[i] && p_rhop[i] == r.nbr && p_rcost[i] < dvrt_pkg::UNREACHABLE)
              p_rcost[i] = clamp_cost(longint'(p_rcost[i]) - longint'(p_nlink[n])
                                      + longint'(c));
          p_nlink[n] = c;
          o.status = dvrt_pkg::ST_OK;
        end
      end
      dvrt_pkg::FN_TICK: begin
        for (int k = 0; k < NN; k++) begin
          if (p_nvalid[k]) begin
            if (p_nsil[k] == p_limit)
              for (int i = 0; i < NR; i++)
                if (p_rvalid[i] && p_rhop[i] == p_naddr[k]) begin
                  p_rhop[i] = '0;
                  p_rcost[i] = dvrt_pkg::UNREACHABLE;
                end
            if (p_nsil[k] < dvrt_pkg::SILENCE_MAX) p_nsil[k]++;
          end
        end
        o.status = dvrt_pkg::ST_OK;
      end
      dvrt_pkg::FN_READ: begin
        if (p_rvalid[r.slot]) begin
          o.status = dvrt_pkg::ST_OK;
          o.dest = p_rdest[r.slot];
          o.hop = p_rhop[r.slot];
          o.cost = p_rcost[r.slot];
          o.vld = 1'b1;
        end
      end
      dvrt_pkg::FN_LOOKUP: begin
        if (r.dest == p_own) begin
          o.status = dvrt_pkg::ST_LOCAL;
          o.dest = r.dest;
          o.hop = p_own;
        end else begin
          for (int i = 0; i < NR; i++)
            if (p_rvalid[i] && p_rdest[i] == r.dest) begin
              o.status = dvrt_pkg::ST_OK;
              o.dest = r.dest;
              o.hop = p_rhop[i];
              o.cost = p_rcost[i];
              o.vld = 1'b1;
              lookups_hit++;
              break;
            end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // result checking and receiver stalls
  always @(posedge clk_i) begin
    route_res_t got, want;
    if (in_valid_i && in_ready_o || res_valid_o && res_ready_i || cfg_valid_i && cfg_ready_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (res_valid_o && res_ready_i) begin
      got = {status_o, out_dest_o, out_next_hop_o, out_cost_o, out_valid_o};
      results_seen <= results_seen + 1;
      if (pending_res.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result: exp none got %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: exp st=%0d d=%h h=%h c=%0d v=%0d  got st=%0d d=%h h=%h c=%0d v=%0d",
                     want.status, want.dest, want.hop, want.cost, want.vld,
                     got.status, got.dest, got.hop, got.cost, got.vld);
        end
      end
    end
  end

  always @(negedge clk_i)
    res_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i)
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("Mismatches found");
      $finish;
    end

  task automatic cfg_write(logic [dvrt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == dvrt_pkg::REG_OWN_ADDRESS) p_own = val;
    else p_limit = val[2:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(route_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= r.func;
    slot_i <= r.slot;
    dest_addr_i <= r.dest;
    hop_addr_i <= r.hop;
    neighbor_addr_i <= r.nbr;
    cost_value_i <= r.cost;
    do @(posedge clk_i); while (!in_ready_o);
    pending_res.insert(pending_res.size(), route_predict(r));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (NN * (NR + 3) + 10) @(posedge clk_i);
  endtask

  // small address pool so adverts, lookups and ticks hit loaded entries
  logic [31:0] addr_pool [8];

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(9) == 0) return $urandom;
    return addr_pool[$urandom_range(7)];
  endfunction

  function automatic logic [23:0] pick_cost();
    case ($urandom_range(9))
      0: return 24'hFFFFFF;
      1: return dvrt_pkg::UNREACHABLE;
      2: return 24'($urandom);
      default: return 24'($urandom_range(200));
    endcase
  endfunction

  function automatic route_req_t random_request();
    route_req_t r;
    int f;
    r.slot = 5'($urandom);
    r.dest = pick_addr();
    r.hop = ($urandom_range(3) == 0) ? p_own : pick_addr();
    r.nbr = pick_addr();
    r.cost = pick_cost();
    f = $urandom_range(99);
    if (f < 14) r.func = dvrt_pkg::FN_LOAD_ROUTE;
    else if (f < 22) r.func = dvrt_pkg::FN_LOAD_NBR;
    else if (f < 45) r.func = dvrt_pkg::FN_ADVERT;
    else if (f < 53) r.func = dvrt_pkg::FN_LINK_COST;
    else if (f < 63) r.func = dvrt_pkg::FN_TICK;
    else if (f < 80) r.func = dvrt_pkg::FN_READ;
    else if (f < 98) r.func = dvrt_pkg::FN_LOOKUP;
    else r.func = FN_UNUSED;
    return r;
  endfunction

  typedef struct packed {
    route_req_t req;
    logic fixed;
    route_res_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(logic [2:0] f, logic [4:0] s, logic [31:0] d,
                                  logic [31:0] h, logic [31:0] nb, logic [23:0] c,
                                  logic fx, route_res_t rs);
    dir_row_t row;
    row.req.func = f;
    row.req.slot = s;
    row.req.dest = d;
    row.req.hop = h;
    row.req.nbr = nb;
    row.req.cost = c;
    row.fixed = fx;
    row.res = rs;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  localparam logic [31:0] A1 = 32'h0A000001;
  localparam logic [31:0] A2 = 32'hFFFFFFFF;
  localparam logic [31:0] D1 = 32'hC0A80001;
  localparam logic [31:0] Z32 = 32'd0;

  initial begin
    route_res_t tr;
    p_own = '0;
    p_limit = dvrt_pkg::SILENCE_RST;
    foreach (p_rvalid[i]) begin
      p_rvalid[i] = 1'b0; p_rdest[i] = '0; p_rhop[i] = '0; p_rcost[i] = '0;
    end
    foreach (p_nvalid[i]) begin
      p_nvalid[i] = 1'b0; p_naddr[i] = '0; p_nlink[i] = '0; p_nsil[i] = '0;
    end
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    addr_pool[0] = A1;
    addr_pool[1] = A2;
    addr_pool[2] = D1;

    // directed table; fixed rows carry expected results
    tr = '0; tr.status = dvrt_pkg::ST_NONE;
    add_row(dvrt_pkg::FN_LOOKUP, 5'd0, D1, Z32, Z32, 24'd0, 1'b1, tr);
    add_row(dvrt_pkg::FN_ADVERT, 5'd0, D1, Z32, A1, 24'd5, 1'b1, tr);
    add_row(dvrt_pkg::FN_LINK_COST, 5'd0, Z32, Z32, A1, 24'd5, 1'b1, tr);
    add_row(dvrt_pkg::FN_LOAD_NBR, 5'd8, Z32, Z32, A1, 24'd1, 1'b1, tr);
    add_row(dvrt_pkg::FN_LOAD_NBR, 5'd31, Z32, Z32, A1, 24'd1, 1'b1, tr);
    add_row(FN_UNUSED, 5'd31, A2, A2, A2, 24'hFFFFFF, 1'b1, tr);
    tr.status = dvrt_pkg::ST_LOCAL;
    add_row(dvrt_pkg::FN_LOOKUP, 5'd0, Z32, Z32, Z32, 24'd0, 1'b1, tr);
    tr = '0;
    add_row(dvrt_pkg::FN_LOAD_NBR, 5'd0, Z32, Z32, A1, 24'd10, 1'b1, tr);
    add_row(dvrt_pkg::FN_LOAD_NBR, 5'd7, Z32, Z32, A2, 24'hFFFFFF, 1'b1, tr);
    add_row(dvrt_pkg::FN_LOAD_ROUTE, 5'd0, D1, A2, Z32, 24'hFFFFFF, 1'b1, tr);
    add_row(dvrt_pkg::FN_LOAD_ROUTE, 5'd31, A2, A1, Z32, 24'd0, 1'b1, tr);
    tr = '{dvrt_pkg::ST_OK, D1, A2, dvrt_pkg::UNREACHABLE, 1'b1};
    add_row(dvrt_pkg::FN_READ, 5'd0, Z32, Z32, Z32, 24'd0, 1'b1, tr);
    tr = '0;
    add_row(dvrt_pkg::FN_ADVERT, 5'd0, D1, Z32, A1, 24'd3, 1'b0, tr);
    add_row(dvrt_pkg::FN_ADVERT, 5'd0, D1, Z32, A1, 24'hFFFFFF, 1'b0, tr);
    add_row(dvrt_pkg::FN_ADVERT, 5'd0, A2, A2, A1, 24'd1, 1'b0, tr);
    add_row(dvrt_pkg::FN_LINK_COST, 5'd0, Z32, Z32, A1, 24'd0, 1'b0, tr);
    add_row(dvrt_pkg::FN_LINK_COST, 5'd0, Z32, Z32, A1, 24'hFFFFFF, 1'b0, tr);
    add_row(dvrt_pkg::FN_READ, 5'd31, Z32, Z32, Z32, 24'd0, 1'b0, tr);
    add_row(dvrt_pkg::FN_READ, 5'd5, Z32, Z32, Z32, 24'd0, 1'b0, tr);
    for (int k = 0; k < 5; k++)
      add_row(dvrt_pkg::FN_TICK, 5'd0, Z32, Z32, Z32, 24'd0, 1'b0, tr);
    add_row(dvrt_pkg::FN_LOOKUP, 5'd0, D1, Z32, Z32, 24'd0, 1'b0, tr);
    add_row(dvrt_pkg::FN_LOOKUP, 5'd0, A2, Z32, Z32, 24'd0, 1'b0, tr);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req);
      if (dir_rows[i].fixed) pending_res[pending_res.size() - 1] = dir_rows[i].res;
    end
    drain_results();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle = 9; recv_idle = 56; end
        2: begin send_idle = 56; recv_idle = 9; end
        4: begin send_idle = 0; recv_idle = 0; end
        default: ;
      endcase
      cfg_write(dvrt_pkg::REG_OWN_ADDRESS,
                (ph == 1) ? A2 : (ph == 5) ? 32'd0 : addr_pool[$urandom_range(7)]);
      cfg_write(dvrt_pkg::REG_SILENCE_LIMIT,
                (ph == 0) ? 32'd1 : (ph == 1) ? 32'd7 : 32'($urandom_range(7, 1)));
      for (int k = 0; k < 308; k++) send_request(random_request());
      drain_results();
    end

    $display("covered %0d results over six register settings", results_seen);
    $display("lookups hitting a route: %0d, routes changed by adverts: %0d",
             lookups_hit, adverts_taken);
    if (mismatches == 0 && pending_res.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
